>>> rtl/b64lw_pkg.sv
// Shared types, constants and the base64 alphabet for the line-wrapping encoder.
package b64lw_pkg;

  localparam int unsigned BurstLen = 6;
  localparam int unsigned BurstCntW = $clog2(BurstLen + 1);

  localparam logic [6:0] CharCr  = 7'd13;
  localparam logic [6:0] CharLf  = 7'd10;
  localparam logic [6:0] CharPad = 7'd61;

  localparam logic [7:0] LineLenReset = 8'd72;
  localparam logic [7:0] LineLenMin   = 8'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } b64lw_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } b64lw_out_t;

  typedef struct packed {
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    logic [7:0]  column_count;
  } b64lw_state_t;

  typedef struct packed {
    logic [BurstLen-1:0][6:0] chars;
    logic [BurstCntW-1:0]     cnt;
    logic                     eom;
  } b64lw_burst_t;

  // Map a six-bit value onto the standard alphabet.
  function automatic logic [6:0] b64lw_alpha(input logic [5:0] idx);
    logic [6:0] code;
    if (idx < 6'd26) begin
      code = 7'd65 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      code = 7'd71 + {1'b0, idx};
    end else if (idx < 6'd62) begin
      code = {1'b0, idx} - 7'd4;
    end else if (idx == 6'd62) begin
      code = 7'd43;
    end else begin
      code = 7'd47;
    end
    return code;
  endfunction

endpackage

>>> rtl/b64lw_enc.sv
// Encode step: group bytes, build the character burst with CR LF, update state.
module b64lw_enc (
  input  b64lw_pkg::b64lw_in_t    item_i,
  input  b64lw_pkg::b64lw_state_t state_i,
  input  logic [7:0]              line_length_i,
  output b64lw_pkg::b64lw_state_t state_o,
  output b64lw_pkg::b64lw_burst_t burst_o
);
  import b64lw_pkg::*;

  logic             grp;
  logic [2:0]       nchars;
  logic [7:0]       b0, b1, b2;
  logic [3:0][5:0]  sext;
  logic [3:0][6:0]  gch;
  logic [7:0]       lim;
  logic [7:0]       col;
  logic [8:0]       diff;
  logic             col_over;
  logic             wrap;
  logic [1:0]       wpos;

  always_comb begin
    state_o = state_i;
    grp     = 1'b0;
    nchars  = 3'd4;
    b0      = state_i.held_bytes[15:8];
    b1      = state_i.held_bytes[7:0];
    b2      = item_i.data_byte;

    // Take in the byte
    if (item_i.byte_valid) begin
      if (state_i.held_count >= 2'd2) begin
        grp                = 1'b1;
        state_o.held_bytes = '0;
        state_o.held_count = 2'd0;
      end else if (state_i.held_count == 2'd1) begin
        state_o.held_bytes = {state_i.held_bytes[15:8], item_i.data_byte};
        state_o.held_count = 2'd2;
      end else begin
        state_o.held_bytes = {item_i.data_byte, 8'd0};
        state_o.held_count = 2'd1;
      end
    end

    // Flush a partial group at the end of the message
    if (item_i.end_of_message) begin
      if (state_o.held_count == 2'd1) begin
        grp    = 1'b1;
        nchars = 3'd2;
        b0     = state_o.held_bytes[15:8];
        b1     = 8'd0;
        b2     = 8'd0;
      end else if (state_o.held_count >= 2'd2) begin
        grp    = 1'b1;
        nchars = 3'd3;
        b0     = state_o.held_bytes[15:8];
        b1     = state_o.held_bytes[7:0];
        b2     = 8'd0;
      end
      state_o.held_bytes = '0;
      state_o.held_count = 2'd0;
    end

    sext[0] = b0[7:2];
    sext[1] = {b0[1:0], b1[7:4]};
    sext[2] = {b1[3:0], b2[7:6]};
    sext[3] = b2[5:0];
    for (int k = 0; k < 4; k++) begin
      gch[k] = (3'(k) < nchars) ? b64lw_alpha(sext[k]) : CharPad;
    end

    // At most one line break fits in four characters since the line is at least four long
    lim      = (line_length_i < LineLenMin) ? LineLenMin : line_length_i;
    col      = state_i.column_count;
    diff     = {1'b0, lim} - {1'b0, col};
    col_over = (col >= lim);
    wrap     = grp && (col_over || diff <= 9'd3);
    wpos     = col_over ? 2'd0 : diff[1:0];

    for (int j = 0; j < BurstLen; j++) begin
      if (!wrap) begin
        burst_o.chars[j] = (j < 4) ? gch[j[1:0]] : CharPad;
      end else if (3'(j) < {1'b0, wpos}) begin
        burst_o.chars[j] = gch[j[1:0]];
      end else if (3'(j) == {1'b0, wpos}) begin
        burst_o.chars[j] = CharCr;
      end else if (3'(j) == {1'b0, wpos} + 3'd1) begin
        burst_o.chars[j] = CharLf;
      end else begin
        burst_o.chars[j] = gch[2'(j - 2)];
      end
    end
    burst_o.cnt = !grp ? BurstCntW'(0) : (wrap ? BurstCntW'(6) : BurstCntW'(4));
    burst_o.eom = item_i.end_of_message;

    if (grp) begin
      state_o.column_count = wrap ? (8'd4 - {6'd0, wpos}) : (col + 8'd4);
    end
    if (item_i.end_of_message) begin
      state_o.column_count = 8'd0;
    end
  end

endmodule

>>> rtl/b64lw_burst.sv
// Result register: holds one burst of characters and shifts them out a word a cycle while the output is not stalled.
module b64lw_burst (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  b64lw_pkg::b64lw_burst_t burst_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output b64lw_pkg::b64lw_out_t   out_word_o
);
  import b64lw_pkg::*;

  logic [BurstLen-1:0][6:0] chars_q, chars_d;
  logic [BurstCntW-1:0]     left_q, left_d;
  logic                     eom_q, eom_d;
  logic                     take;

  assign out_valid_o = (left_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (left_q == '0) || (left_q == BurstCntW'(1) && !out_stall_i);

  assign out_word_o.char_code = chars_q[0];
  assign out_word_o.last_char = eom_q && (left_q == BurstCntW'(1));

  always_comb begin
    chars_d = chars_q;
    left_d  = left_q;
    eom_d   = eom_q;
    if (load_i) begin
      chars_d = burst_i.chars;
      left_d  = burst_i.cnt;
      eom_d   = burst_i.eom;
    end else if (take) begin
      for (int i = 0; i < BurstLen - 1; i++) begin
        chars_d[i] = chars_q[i+1];
      end
      left_d = left_q - BurstCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      eom_q  <= 1'b0;
    end else begin
      left_q <= left_d;
      eom_q  <= eom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

>>> rtl/base64_encoder_line_wrap_core.sv
// Top level of the streaming base64 encoder with CR LF line wrapping.
//
//   channel   direction  payload                 handshake
//   in        input      in_word_i  (b64lw_in_t)  in_valid_i / in_stall_o
//   out       output     out_word_o (b64lw_out_t) out_valid_o / out_stall_i
//   cfg       input      cfg_data_i (line length) cfg_we_i
//
// An input word lands in the input register, is encoded combinationally and its
// burst of four or six characters is loaded into the result register, which
// emits one character a cycle while the output is not stalled. A word that
// yields no character (first or second byte of a group) moves on even while
// a burst drains. Reset clears the held bytes, column count and both stages;
// line length returns to 72. A stall on the output holds the burst and backs
// up the input.
module base64_encoder_line_wrap_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  b64lw_pkg::b64lw_in_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output b64lw_pkg::b64lw_out_t out_word_o,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i
);
  import b64lw_pkg::*;

  // Input register
  logic         in_vld_q, in_vld_d;
  b64lw_in_t    in_q;

  // Encoder state and configuration
  b64lw_state_t state_q, state_d;
  logic [7:0]   line_len_q;

  b64lw_burst_t burst;
  logic         has_out;
  logic         buf_free;
  logic         move;
  logic         accept;

  b64lw_enc u_enc (
    .item_i        (in_q),
    .state_i       (state_q),
    .line_length_i (line_len_q),
    .state_o       (state_d),
    .burst_o       (burst)
  );

  // Advance a word with no characters at once; one with a burst waits for the result register
  assign has_out    = (burst.cnt != '0);
  assign move       = in_vld_q && (buf_free || !has_out);
  assign in_stall_o = in_vld_q && !move;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      state_q    <= '0;
      line_len_q <= LineLenReset;
    end else begin
      in_vld_q <= in_vld_d;
      if (move) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        line_len_q <= cfg_data_i;
      end
    end
  end

  // Hold the payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

  b64lw_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (move && has_out),
    .burst_i     (burst),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/b64lw_chk.sv
// Port checker for the encoder, bound to the top level.
module b64lw_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input b64lw_pkg::b64lw_out_t out_word_o
);
  import b64lw_pkg::*;

  logic take;
  assign take = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && out_word_o.char_code == CharCr |=> out_valid_o && out_word_o.char_code == CharLf)
    else $error("CR not followed at once by LF");

  a_lf_then_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && out_word_o.char_code == CharLf |=>
      out_valid_o && out_word_o.char_code != CharCr && out_word_o.char_code != CharLf)
    else $error("line break not followed by a character");

  a_last_not_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last_char |->
      out_word_o.char_code != CharCr && out_word_o.char_code != CharLf)
    else $error("final word is a line break");

endmodule

bind base64_encoder_line_wrap_core b64lw_chk u_b64lw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

>>> test/tb_base64_encoder_line_wrap_core.sv
// Self-checking testbench for the line-wrapping base64 encoder core.
`timescale 1ns / 100ps

module tb_base64_encoder_line_wrap_core;
  import b64lw_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned ErrShowMax = 10;
  localparam int unsigned RandWordsPerPhase = 15;

  // One queued input word and the idle cycles that follow its acceptance.
  typedef struct {
    b64lw_in_t   w;
    int unsigned gap;
  } pending_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  b64lw_in_t  in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  b64lw_out_t out_word;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = '0;

  base64_encoder_line_wrap_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // Words waiting to be driven, and characters the encoder still owes us.
  pending_word_t word_q[$];
  b64lw_out_t    owed_chars[$];

  // Encoder state as the checker sees it.
  logic [7:0]  line_len = LineLenReset;
  logic [15:0] held_pair = '0;
  logic [1:0]  held_n = '0;
  logic [7:0]  line_col = '0;
  string       b64_alpha =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  logic        quiet = 1'b0;
  int unsigned wait_left = 0;
  int unsigned stall_left = 0;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned char_cnt = 0;
  int unsigned msg_cnt = 0;
  int unsigned data_word_cnt = 0;
  int unsigned phase_cnt = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned draw_idle();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= ErrShowMax) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // Emit one character, breaking the line first once it is full.
  task automatic emit_char(input logic [6:0] code, inout int unsigned n_new);
    logic [7:0] lim;
    lim = (line_len < LineLenMin) ? LineLenMin : line_len;
    if (line_col >= lim) begin
      owed_chars.push_back('{char_code: CharCr, last_char: 1'b0});
      owed_chars.push_back('{char_code: CharLf, last_char: 1'b0});
      line_col = '0;
      n_new += 2;
    end
    owed_chars.push_back('{char_code: code, last_char: 1'b0});
    line_col = line_col + 8'd1;
    n_new++;
  endtask

  // Split three bytes into sextets; pad past nchars with '='.
  task automatic emit_group(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input int unsigned nchars,
                            inout int unsigned n_new);
    logic [5:0] sx [4];
    logic [6:0] code;
    sx[0] = b0[7:2];
    sx[1] = {b0[1:0], b1[7:4]};
    sx[2] = {b1[3:0], b2[7:6]};
    sx[3] = b2[5:0];
    for (int k = 0; k < 4; k++) begin
      code = (k < nchars) ? 7'(b64_alpha[int'(sx[k])]) : CharPad;
      emit_char(code, n_new);
    end
  endtask

  // Work out the characters that one accepted word gives.
  task automatic encode_word(input b64lw_in_t w);
    int unsigned n_new;
    b64lw_out_t  tail;
    n_new = 0;
    if (w.byte_valid) begin
      if (held_n == 2'd2) begin
        emit_group(held_pair[15:8], held_pair[7:0], w.data_byte, 4, n_new);
        held_pair = '0;
        held_n = '0;
      end else if (held_n == 2'd1) begin
        held_pair[7:0] = w.data_byte;
        held_n = 2'd2;
      end else begin
        held_pair = {w.data_byte, 8'h00};
        held_n = 2'd1;
      end
    end
    if (w.end_of_message) begin
      if (held_n == 2'd1) begin
        emit_group(held_pair[15:8], 8'h00, 8'h00, 2, n_new);
      end else if (held_n == 2'd2) begin
        emit_group(held_pair[15:8], held_pair[7:0], 8'h00, 3, n_new);
      end
      if (n_new != 0) begin
        tail = owed_chars.pop_back();
        tail.last_char = 1'b1;
        owed_chars.push_back(tail);
      end
      held_pair = '0;
      held_n = '0;
      line_col = '0;
    end
  endtask

  task automatic check_char(input b64lw_out_t got);
    b64lw_out_t want;
    char_cnt++;
    if (owed_chars.size() == 0) begin
      note_error($sformatf("unexpected char 0x%02h last=%0b",
                           got.char_code, got.last_char));
    end else begin
      want = owed_chars.pop_front();
      if (got.char_code !== want.char_code || got.last_char !== want.last_char) begin
        note_error($sformatf("char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                             want.char_code, want.last_char,
                             got.char_code, got.last_char));
      end
    end
  endtask

  // Sample both channels and the config port at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_cnt++;
      if (cfg_we) begin
        line_len = cfg_data;
      end
      // Predict before checking, so a same-cycle character would still match.
      if (in_valid && !in_stall) begin
        encode_word(in_word);
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        check_char(out_word);
      end
      in_taken <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;
      if (cycle_cnt > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Input driver: hold a stalled word, then idle for its gap, then load the next.
  always @(negedge clk) begin : drive_blk
    pending_word_t nxt;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (wait_left != 0) begin
        in_valid <= 1'b0;
        wait_left <= wait_left - 1;
      end else if (word_q.size() != 0) begin
        nxt = word_q.pop_front();
        in_valid <= 1'b1;
        in_word <= nxt.w;
        wait_left <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: draw a fresh stall run after every accepted character.
  always @(negedge clk) begin : stall_blk
    int unsigned n;
    n = out_taken ? draw_idle() : stall_left;
    if (n != 0) begin
      out_stall <= 1'b1;
      stall_left <= n - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  task automatic queue_word(input logic [7:0] d, input logic v, input logic e);
    pending_word_t pw;
    pw.w.data_byte = d;
    pw.w.byte_valid = v;
    pw.w.end_of_message = e;
    pw.gap = draw_idle();
    word_q.push_back(pw);
    queued_cnt++;
    if (v || e) begin
      data_word_cnt++;
    end
  endtask

  // Queue one message; end it on its last byte or with a bare flush.
  task automatic queue_message(input int unsigned len, input bit bare_end);
    for (int unsigned i = 0; i < len; i++) begin
      // Drop in the odd ignored word to make sure stray data is discarded.
      if ($urandom_range(0, 11) == 0) begin
        queue_word(8'($urandom), 1'b0, 1'b0);
      end
      queue_word(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) begin
      queue_word(8'($urandom), 1'b0, 1'b1);
    end
    msg_cnt++;
  endtask

  // Let traffic drain fully, then change the line length.
  task automatic set_line_length(input logic [7:0] len);
    while (accepted_cnt != queued_cnt || owed_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    phase_cnt++;
  endtask

  initial begin : stim_blk
    logic [7:0]  phase_len [7];
    int unsigned phase_words;
    int unsigned len;

    phase_len = '{8'd4, 8'd255, 8'd3, 8'd5, 8'd1, 8'($urandom_range(6, 100)), 8'd72};

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, ignored data, all three padding shapes,
    // bare flushes after one, two and three bytes, byte extremes.
    queue_word(8'h5a, 1'b0, 1'b1);
    queue_word(8'ha5, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b1);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'hff, 1'b1, 1'b1);
    queue_word(8'h00, 1'b1, 1'b0);
    queue_word(8'h10, 1'b1, 1'b0);
    queue_word(8'h83, 1'b1, 1'b1);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'hff, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(8'h80, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    queue_word(8'h7f, 1'b1, 1'b0);
    queue_word(8'h01, 1'b1, 1'b0);
    queue_word(8'h00, 1'b0, 1'b1);
    msg_cnt += 7;

    // Zero line length behaves as four: exact fill with no trailing break,
    // then a wrap through the padding.
    set_line_length(8'd0);
    queue_message(3, 1'b0);
    queue_message(7, 1'b0);

    // Random phases, one per line length; every other phase runs without idling.
    for (int p = 0; p < 7; p++) begin
      quiet = p[0];
      set_line_length(phase_len[p]);
      phase_words = data_word_cnt;
      // Make sure a long line still wraps at least once.
      if (line_len > 8'd100) begin
        queue_message(200, 1'($urandom_range(0, 1)));
      end
      while (data_word_cnt - phase_words < RandWordsPerPhase) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(1, 24);
        queue_message(len, 1'($urandom_range(0, 1)));
      end
    end

    while (accepted_cnt != queued_cnt || owed_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles * 2) @(posedge clk);

    if (owed_chars.size() != 0) begin
      err_cnt += owed_chars.size();
      $display("%0d characters never arrived", owed_chars.size());
    end
    $display("Encoded %0d messages from %0d words into %0d characters",
             msg_cnt, data_word_cnt, char_cnt);
    $display("Covered %0d line-length settings, with and without idling on both sides",
             phase_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
